@@ design/rmth_pkg.sv @@
// Package: shared widths, constants and control structs for the running median block.
`timescale 1ns / 1ps
`default_nettype none
package rmth_pkg;
	localparam int CAPACITY_DEF    = 1024;
	localparam int SAMPLE_BITS_DEF = 32;
	localparam int IN_W            = 32;
	localparam int MED_W           = 33;
	localparam int CNT_W           = 11;

	// Heap operations the controller asks of the datapath.
	typedef enum logic [2:0] {
		OP_NONE,
		OP_LOAD,      // capture sample
		OP_PUSH_UP,   // write tail of a heap, then sift up
		OP_REPLACE,   // write root of a heap, then sift down
		OP_STEP       // one sift step
	} dp_op_t;

	typedef struct packed {
		dp_op_t op;
		logic   heap_sel;   // 1: lower (max) heap, 0: upper (min) heap
		logic   use_other;  // value is the other heap's top rather than the sample
		logic   grow;       // size of heap_sel increases
	} dp_cmd_t;

	typedef struct packed {
		logic busy;       // sift in progress
		logic go_lower;   // sample belongs to lower half
		logic low_full;   // lower has one more than upper
		logic up_first;   // upper not empty and sample above upper top
		logic full;       // store at capacity
	} dp_stat_t;
endpackage
`default_nettype wire

@@ design/rmth_if.sv @@
// Interfaces: valid/ready channels for samples and median results.
`timescale 1ns / 1ps
`default_nettype none
interface rmth_in_if;
	logic                       valid;
	logic                       ready;
	logic [rmth_pkg::IN_W-1:0]  sample;
	modport source (output valid, output sample, input ready);
	modport sink   (input valid, input sample, output ready);
endinterface

interface rmth_out_if;
	logic                        valid;
	logic                        ready;
	logic [rmth_pkg::MED_W-1:0]  median_twice;
	logic [rmth_pkg::CNT_W-1:0]  stored_count;
	logic                        rejected;
	modport source (output valid, output median_twice, output stored_count, output rejected,
		input ready);
	modport sink   (input valid, input median_twice, input stored_count, input rejected,
		output ready);
endinterface
`default_nettype wire

@@ design/rmth_heap.sv @@
// Datapath: two heap memories, sizes and a shared sift unit.
`timescale 1ns / 1ps
`default_nettype none
module rmth_heap #(
	parameter int CAPACITY    = rmth_pkg::CAPACITY_DEF,
	parameter int SAMPLE_BITS = rmth_pkg::SAMPLE_BITS_DEF
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire [rmth_pkg::IN_W-1:0]   sample,
	input  rmth_pkg::dp_cmd_t          cmd,
	output rmth_pkg::dp_stat_t         stat,
	output logic [rmth_pkg::MED_W-1:0] median_twice,
	output logic [rmth_pkg::CNT_W-1:0] stored_count
);
	localparam int LCAP = (CAPACITY + 1) / 2;
	localparam int UCAP = CAPACITY / 2;
	localparam int AW   = $clog2(LCAP) < 1 ? 1 : $clog2(LCAP);
	localparam int SW   = $clog2(LCAP + 1);
	localparam int TW   = $clog2(CAPACITY + 1);

	// Sift sequencer phases: read parent or children, then compare and swap.
	typedef enum logic [2:0] {S_IDLE, S_UP_RD, S_UP_CMP, S_DN_RD, S_DN_RD2, S_DN_CMP, S_FIN}
		sift_t;

	logic [SAMPLE_BITS-1:0] lmem [LCAP];
	logic [SAMPLE_BITS-1:0] umem [UCAP];
	logic [SW-1:0]          lsize_q, usize_q;
	logic [SAMPLE_BITS-1:0] ltop_q, utop_q, samp_q, cur_q;
	logic [SAMPLE_BITS-1:0] rd_q;
	logic [AW:0]            pos_q;
	logic                   hsel_q;
	logic [SW-1:0]          hsize_q;
	sift_t                  sift_q;

	// memory read port: one address shared by both heaps
	logic [AW-1:0]          raddr;
	logic [SAMPLE_BITS-1:0] lrd_q, urd_q;
	logic                   we;
	logic [AW-1:0]          waddr;
	logic [SAMPLE_BITS-1:0] wdata;
	logic                   whsel;

	logic [AW:0]            parent;
	logic [AW+1:0]          lchild, rchild;
	logic                   r_ok, l_ok;
	logic [SAMPLE_BITS-1:0] newval, rdh, rd2h;
	logic [SAMPLE_BITS-1:0] best;
	logic [AW:0]            best_pos;
	logic                   swap;

	function automatic logic above(input logic [SAMPLE_BITS-1:0] a,
		input logic [SAMPLE_BITS-1:0] b, input logic is_max);
		above = is_max ? ($signed(a) > $signed(b)) : ($signed(a) < $signed(b));
	endfunction

	assign parent = (pos_q - 1'b1) >> 1;
	assign lchild = {pos_q, 1'b1};
	assign rchild = lchild + 1'b1;
	assign l_ok   = (lchild < (AW+2)'(hsize_q));
	assign r_ok   = (rchild < (AW+2)'(hsize_q));
	assign rdh    = hsel_q ? lrd_q : urd_q;
	assign rd2h   = rd_q;
	assign newval = cmd.use_other ? (cmd.heap_sel ? utop_q : ltop_q) : samp_q;

	// children compare: rd_q holds left child, rdh the right child
	always_comb begin
		best = cur_q;
		best_pos = pos_q;
		if (l_ok && above(rd2h, best, hsel_q)) begin
			best = rd2h;
			best_pos = lchild[AW:0];
		end
		if (r_ok && above(rdh, best, hsel_q)) begin
			best = rdh;
			best_pos = rchild[AW:0];
		end
	end

	always_comb begin
		raddr = '0;
		unique case (sift_q)
			S_UP_RD:  raddr = parent[AW-1:0];
			S_DN_RD:  raddr = lchild[AW-1:0];
			S_DN_RD2: raddr = rchild[AW-1:0];
			default:  raddr = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		lrd_q <= lmem[raddr];
		if (raddr < AW'(UCAP) || UCAP == LCAP) urd_q <= umem[raddr[AW-1:0]];
		if (we && whsel) lmem[waddr] <= wdata;
		if (we && !whsel) umem[waddr] <= wdata;
	end

	assign swap = (sift_q == S_UP_CMP) ? above(cur_q, rdh, hsel_q) : (best_pos != pos_q);

	// The moving value lives in cur_q; it is written at its final position when sifting stops.
	always_comb begin
		we = 1'b0;
		waddr = '0;
		wdata = '0;
		whsel = hsel_q;
		if (cmd.op == rmth_pkg::OP_PUSH_UP) begin
			we = 1'b1;
			whsel = cmd.heap_sel;
			waddr = cmd.heap_sel ? lsize_q[AW-1:0] : usize_q[AW-1:0];
			wdata = newval;
		end else if (cmd.op == rmth_pkg::OP_REPLACE) begin
			we = 1'b1;
			whsel = cmd.heap_sel;
			waddr = '0;
			wdata = newval;
		end else if (sift_q == S_UP_CMP) begin
			// On a swap the parent value moves down, otherwise the moving value settles here.
			we = 1'b1;
			waddr = pos_q[AW-1:0];
			wdata = swap ? rdh : cur_q;
		end else if (sift_q == S_DN_CMP) begin
			we = 1'b1;
			waddr = pos_q[AW-1:0];
			wdata = swap ? best : cur_q;
		end else if (sift_q == S_FIN) begin
			we = 1'b1;
			waddr = pos_q[AW-1:0];
			wdata = cur_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lsize_q <= '0;
			usize_q <= '0;
			sift_q  <= S_IDLE;
			pos_q   <= '0;
			hsel_q  <= 1'b0;
			hsize_q <= '0;
		end else begin
			unique case (sift_q)
				S_IDLE: begin
					if (cmd.op == rmth_pkg::OP_PUSH_UP) begin
						hsel_q  <= cmd.heap_sel;
						pos_q   <= cmd.heap_sel ? (AW+1)'(lsize_q) : (AW+1)'(usize_q);
						sift_q  <= ((cmd.heap_sel ? lsize_q : usize_q) == '0) ? S_IDLE : S_UP_RD;
						if (cmd.heap_sel) lsize_q <= lsize_q + 1'b1;
						else usize_q <= usize_q + 1'b1;
					end else if (cmd.op == rmth_pkg::OP_REPLACE) begin
						hsel_q  <= cmd.heap_sel;
						pos_q   <= '0;
						hsize_q <= cmd.heap_sel ? lsize_q : usize_q;
						sift_q  <= S_DN_RD;
					end
				end
				S_UP_RD:  sift_q <= S_UP_CMP;
				S_UP_CMP: begin
					if (swap) begin
						pos_q  <= parent;
						sift_q <= (parent == '0) ? S_FIN : S_UP_RD;
					end else sift_q <= S_IDLE;
				end
				S_DN_RD:  sift_q <= S_DN_RD2;
				S_DN_RD2: sift_q <= S_DN_CMP;
				S_DN_CMP: begin
					if (swap) begin
						pos_q  <= best_pos;
						sift_q <= S_DN_RD;
					end else sift_q <= S_IDLE;
				end
				S_FIN:    sift_q <= S_IDLE;
				default: sift_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers: sample, moving value and cached tops.
	always_ff @(posedge clk) begin
		if (sift_q == S_DN_RD2) rd_q <= rdh;
		if (cmd.op == rmth_pkg::OP_LOAD) samp_q <= sample[SAMPLE_BITS-1:0];
		if (cmd.op == rmth_pkg::OP_PUSH_UP || cmd.op == rmth_pkg::OP_REPLACE) begin
			cur_q <= newval;
			if (cmd.op == rmth_pkg::OP_REPLACE) begin
				if (cmd.heap_sel) ltop_q <= newval;
				else utop_q <= newval;
			end else if (cmd.heap_sel ? (lsize_q == '0) : (usize_q == '0)) begin
				if (cmd.heap_sel) ltop_q <= newval;
				else utop_q <= newval;
			end
		end
		// top changes as the sift moves things through the root
		if (sift_q == S_UP_CMP && swap && parent == '0) begin
			if (hsel_q) ltop_q <= cur_q;
			else utop_q <= cur_q;
		end
		if (sift_q == S_DN_CMP && swap && pos_q == '0) begin
			if (hsel_q) ltop_q <= best;
			else utop_q <= best;
		end
	end

	logic [TW-1:0] total;
	assign total = TW'(lsize_q) + TW'(usize_q);

	assign stat.busy     = (sift_q != S_IDLE);
	assign stat.go_lower = (lsize_q == '0) || ($signed(samp_q) <= $signed(ltop_q));
	assign stat.low_full = (lsize_q == usize_q + 1'b1);
	assign stat.up_first = (usize_q != '0) && ($signed(samp_q) > $signed(utop_q));
	assign stat.full     = (total >= TW'(CAPACITY));

	always_comb begin
		median_twice = '0;
		if (lsize_q > usize_q)
			median_twice = {{(rmth_pkg::MED_W-SAMPLE_BITS){ltop_q[SAMPLE_BITS-1]}}, ltop_q} << 1;
		else if (lsize_q != '0 && usize_q != '0)
			median_twice = rmth_pkg::MED_W'($signed(ltop_q)) + rmth_pkg::MED_W'($signed(utop_q));
	end
	assign stored_count = rmth_pkg::CNT_W'(total);
endmodule
`default_nettype wire

@@ design/rmth_ctrl.sv @@
// Controller: sequences the heap operations for one item and strobes the load of the result register.
`timescale 1ns / 1ps
`default_nettype none
module rmth_ctrl (
	input  wire                clk,
	input  wire                arst_n,
	input  wire                in_valid,
	output logic               in_ready,
	output logic               out_valid,
	input  wire                out_ready,
	output logic               load_res,
	output logic               rej_q,
	output rmth_pkg::dp_cmd_t  cmd,
	input  rmth_pkg::dp_stat_t stat
);
	typedef enum logic [2:0] {ST_IDLE, ST_DECIDE, ST_OP1, ST_WAIT1, ST_OP2, ST_WAIT2, ST_DONE}
		state_t;
	state_t state_q;
	logic   two_q, hsel2_q, other2_q;
	rmth_pkg::dp_cmd_t cmd1_q;

	assign in_ready = (state_q == ST_IDLE) && !out_valid;
	assign load_res = (state_q == ST_DONE);

	always_comb begin
		cmd = '{op: rmth_pkg::OP_NONE, heap_sel: 1'b0, use_other: 1'b0, grow: 1'b0};
		unique case (state_q)
			ST_IDLE:  if (in_valid && in_ready) cmd.op = rmth_pkg::OP_LOAD;
			ST_OP1:   cmd = cmd1_q;
			ST_OP2:   cmd = '{op: rmth_pkg::OP_REPLACE, heap_sel: hsel2_q,
				use_other: other2_q, grow: 1'b0};
			default:  ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= ST_IDLE;
			out_valid <= 1'b0;
			rej_q     <= 1'b0;
			two_q     <= 1'b0;
			hsel2_q   <= 1'b0;
			other2_q  <= 1'b0;
			cmd1_q    <= '{op: rmth_pkg::OP_NONE, heap_sel: 1'b0, use_other: 1'b0, grow: 1'b0};
		end else begin
			if (out_valid && out_ready) out_valid <= 1'b0;
			unique case (state_q)
				ST_IDLE: if (in_valid && in_ready) state_q <= ST_DECIDE;
				ST_DECIDE: begin
					rej_q <= stat.full;
					two_q <= 1'b0;
					if (stat.full) state_q <= ST_DONE;
					else begin
						state_q <= ST_OP1;
						if (stat.go_lower && stat.low_full) begin
							// lower top moves up, sample replaces it
							cmd1_q <= '{op: rmth_pkg::OP_PUSH_UP, heap_sel: 1'b0,
								use_other: 1'b1, grow: 1'b1};
							two_q <= 1'b1; hsel2_q <= 1'b1; other2_q <= 1'b0;
						end else if (stat.go_lower) begin
							cmd1_q <= '{op: rmth_pkg::OP_PUSH_UP, heap_sel: 1'b1,
								use_other: 1'b0, grow: 1'b1};
						end else if (!stat.low_full && stat.up_first) begin
							// upper top moves down, sample replaces it
							cmd1_q <= '{op: rmth_pkg::OP_PUSH_UP, heap_sel: 1'b1,
								use_other: 1'b1, grow: 1'b1};
							two_q <= 1'b1; hsel2_q <= 1'b0; other2_q <= 1'b0;
						end else if (!stat.low_full) begin
							cmd1_q <= '{op: rmth_pkg::OP_PUSH_UP, heap_sel: 1'b1,
								use_other: 1'b0, grow: 1'b1};
						end else begin
							cmd1_q <= '{op: rmth_pkg::OP_PUSH_UP, heap_sel: 1'b0,
								use_other: 1'b0, grow: 1'b1};
						end
					end
				end
				ST_OP1:   state_q <= ST_WAIT1;
				ST_WAIT1: if (!stat.busy) state_q <= two_q ? ST_OP2 : ST_DONE;
				ST_OP2:   state_q <= ST_WAIT2;
				ST_WAIT2: if (!stat.busy) state_q <= ST_DONE;
				ST_DONE: begin
					out_valid <= 1'b1;
					state_q   <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end
endmodule
`default_nettype wire

@@ design/running_median_two_heaps.sv @@
// Top level: running median over two heaps with valid/ready channels.
// Usage:
// Samples arrive on the in channel, one item per handshake; for every item one
// result item leaves on the out channel carrying twice the median, the count of
// stored samples and a reject flag that is set when the store was already full.
// From the accepting edge the result waits on the control states and on the sift
// sequencer: each heap level passed in the sift up takes a parent read and a
// compare (and a final write when it reaches the root), and each level compared
// in the sift down takes a left child read, a right child read and a compare, as
// each heap memory has a single read port. Items are handled one at a time, and
// the next sample is taken in the cycle after the result has been accepted.
// The result sits in an output register; while the receiver stalls, the block
// holds it and takes no new sample. Reset empties both heaps at once through
// their size counters; no clearing pass is needed, and heap contents are
// undefined until written.
`timescale 1ns / 1ps
`default_nettype none
module running_median_two_heaps #(
	parameter int CAPACITY    = rmth_pkg::CAPACITY_DEF,
	parameter int SAMPLE_BITS = rmth_pkg::SAMPLE_BITS_DEF
) (
	input  wire        clk,
	input  wire        arst_n,
	rmth_in_if.sink    in_ch,
	rmth_out_if.source out_ch
);
	rmth_pkg::dp_cmd_t  cmd;
	rmth_pkg::dp_stat_t stat;
	logic [rmth_pkg::MED_W-1:0] med;
	logic [rmth_pkg::CNT_W-1:0] cnt;
	logic load_res, rej;
	logic [rmth_pkg::MED_W-1:0] med_q;
	logic [rmth_pkg::CNT_W-1:0] cnt_q;

	rmth_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_ch.valid), .in_ready(in_ch.ready),
		.out_valid(out_ch.valid), .out_ready(out_ch.ready),
		.load_res(load_res), .rej_q(rej), .cmd(cmd), .stat(stat)
	);

	rmth_heap #(.CAPACITY(CAPACITY), .SAMPLE_BITS(SAMPLE_BITS)) u_heap (
		.clk(clk), .arst_n(arst_n), .sample(in_ch.sample), .cmd(cmd), .stat(stat),
		.median_twice(med), .stored_count(cnt)
	);

	always_ff @(posedge clk) begin
		if (load_res) begin
			med_q <= med;
			cnt_q <= cnt;
		end
	end

	assign out_ch.median_twice = med_q;
	assign out_ch.stored_count = cnt_q;
	assign out_ch.rejected     = rej;
endmodule
`default_nettype wire

@@ design/rmth_checks.sv @@
// Checker: port-level assertions for the running median block, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module rmth_checks (
	input wire                        clk,
	input wire                        arst_n,
	input wire                        in_valid,
	input wire                        in_ready,
	input wire                        out_valid,
	input wire                        out_ready,
	input wire [rmth_pkg::MED_W-1:0]  median_twice,
	input wire [rmth_pkg::CNT_W-1:0]  stored_count,
	input wire                        rejected
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(median_twice))
		else $error("result changed while stalled");
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !in_ready)
		else $error("sample taken while a result waits");
	a_no_early: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !out_valid)
		else $error("result shown in the cycle after a sample");
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> stored_count != '0)
		else $error("result with empty store");
	a_rej: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && rejected |-> stored_count != '0)
		else $error("reject with empty store");
endmodule

bind running_median_two_heaps rmth_checks u_checks (
	.clk(clk), .arst_n(arst_n),
	.in_valid(in_ch.valid), .in_ready(in_ch.ready),
	.out_valid(out_ch.valid), .out_ready(out_ch.ready),
	.median_twice(out_ch.median_twice), .stored_count(out_ch.stored_count),
	.rejected(out_ch.rejected)
);
`default_nettype wire
